### hdl/rmsdw_pkg.sv
// shared constants and types for the rms error dual window tracker
package rmsdw_pkg;

    localparam int WINDOW = 1024;

    localparam int VAL_W  = 16;
    localparam int ERR_W  = 17;
    localparam int SQ_W   = 2 * VAL_W;
    localparam int ACC_W  = 36;
    localparam int CNT_W  = 16;
    localparam int RMS_W  = 16;
    localparam int OSUM_W = 26;

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int SUM_W  = (RMS_W + IDX_W > OSUM_W) ? RMS_W + IDX_W : OSUM_W;
    localparam int WIN_W  = $clog2(WINDOW + 1);
    localparam int DVS_W  = (WIN_W > CNT_W) ? WIN_W : CNT_W;

    localparam int ROOT_W = ACC_W / 2;
    localparam int SQR_W  = ROOT_W + 2;
    localparam int DCNT_W = $clog2(ACC_W);
    localparam int SCNT_W = $clog2(ROOT_W);

    // one vector of nominal length fits
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic                    last;
        logic [ACC_W-1:0]        acc;
        logic [CNT_W-1:0]        cnt;
    } qent_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

### hdl/rms_error_dual_window_tracker.sv
// top level of the rms error dual window tracker
//
//  channel | handshake            | word
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_stall  | target_value, actual_value, last_component
//  out     | out_valid / out_stall| component_error, vector_done, vector_rms,
//          |                      | newer_window_sum, older_window_sum,
//          |                      | average_error
//
// front end takes one word a cycle while the four-entry queue has room
// a word that is not a last component goes from the queue straight to the result register
// a last component leaves the queue, then passes the one-bit divider for the mean,
// the two-bit root unit, one ring write and one result load
// after reset both rings are cleared entry by entry with in_stall high
// out_stall holds the result register; the queue keeps filling behind it
module rms_error_dual_window_tracker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [rmsdw_pkg::VAL_W-1:0]  target_value,
    input  logic signed [rmsdw_pkg::VAL_W-1:0]  actual_value,
    input  logic                                last_component,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [rmsdw_pkg::ERR_W-1:0]  component_error,
    output logic                                vector_done,
    output logic [rmsdw_pkg::RMS_W-1:0]         vector_rms,
    output logic [rmsdw_pkg::OSUM_W-1:0]        newer_window_sum,
    output logic [rmsdw_pkg::OSUM_W-1:0]        older_window_sum,
    output logic [rmsdw_pkg::RMS_W-1:0]         average_error
);

    logic               push;
    logic               pop;
    logic               clearing;
    rmsdw_pkg::qent_t   push_data;
    rmsdw_pkg::qent_t   pop_data;
    rmsdw_pkg::qstat_t  qstat;

    rmsdw_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .target_value   (target_value),
        .actual_value   (actual_value),
        .last_component (last_component),
        .hold           (clearing),
        .qstat          (qstat),
        .push           (push),
        .push_data      (push_data)
    );

    rmsdw_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    rmsdw_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .qstat            (qstat),
        .qdata            (pop_data),
        .pop              (pop),
        .clearing         (clearing),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .component_error  (component_error),
        .vector_done      (vector_done),
        .vector_rms       (vector_rms),
        .newer_window_sum (newer_window_sum),
        .older_window_sum (older_window_sum),
        .average_error    (average_error)
    );

endmodule

### hdl/rmsdw_front.sv
// front end: takes words, forms the error and square, accumulates per vector
module rmsdw_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [rmsdw_pkg::VAL_W-1:0]  target_value,
    input  logic signed [rmsdw_pkg::VAL_W-1:0]  actual_value,
    input  logic                                last_component,
    input  logic                                hold,
    input  rmsdw_pkg::qstat_t                   qstat,
    output logic                                push,
    output rmsdw_pkg::qent_t                    push_data
);

    logic                                s1_valid_reg;
    logic                                s1_valid_next;
    logic signed [rmsdw_pkg::ERR_W-1:0]  s1_err_reg;
    logic [rmsdw_pkg::SQ_W-1:0]          s1_sq_reg;
    logic                                s1_last_reg;
    logic [rmsdw_pkg::ACC_W-1:0]         acc_reg;
    logic [rmsdw_pkg::ACC_W-1:0]         acc_next;
    logic [rmsdw_pkg::CNT_W-1:0]         cnt_reg;
    logic [rmsdw_pkg::CNT_W-1:0]         cnt_next;

    logic                                accept;
    logic signed [rmsdw_pkg::ERR_W-1:0]  err_c;
    logic [rmsdw_pkg::ERR_W-1:0]         neg_c;
    logic [rmsdw_pkg::VAL_W-1:0]         mag_c;
    logic [rmsdw_pkg::SQ_W-1:0]          sq_c;
    logic [rmsdw_pkg::ACC_W:0]           acc_sum;
    logic [rmsdw_pkg::ACC_W-1:0]         acc_new;
    logic [rmsdw_pkg::CNT_W-1:0]         cnt_new;

    assign in_stall = hold || (s1_valid_reg && qstat.full);
    assign accept   = in_valid && !in_stall;
    assign push     = s1_valid_reg && !qstat.full;

    assign err_c = $signed({target_value[rmsdw_pkg::VAL_W-1], target_value})
                 - $signed({actual_value[rmsdw_pkg::VAL_W-1], actual_value});
    assign neg_c = -err_c;
    assign mag_c = err_c[rmsdw_pkg::ERR_W-1] ? neg_c[rmsdw_pkg::VAL_W-1:0]
                                             : err_c[rmsdw_pkg::VAL_W-1:0];
    assign sq_c  = mag_c * mag_c;

    // saturating accumulate and count
    assign acc_sum = {1'b0, acc_reg} + (rmsdw_pkg::ACC_W + 1)'(s1_sq_reg);
    assign acc_new = acc_sum[rmsdw_pkg::ACC_W] ? '1 : acc_sum[rmsdw_pkg::ACC_W-1:0];
    assign cnt_new = (&cnt_reg) ? cnt_reg : cnt_reg + 1'b1;

    assign push_data.err  = s1_err_reg;
    assign push_data.last = s1_last_reg;
    assign push_data.acc  = acc_new;
    assign push_data.cnt  = cnt_new;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        if (push)
        begin
            s1_valid_next = 1'b0;
            acc_next      = s1_last_reg ? '0 : acc_new;
            cnt_next      = s1_last_reg ? '0 : cnt_new;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            acc_reg      <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_err_reg  <= err_c;
            s1_sq_reg   <= sq_c;
            s1_last_reg <= last_component;
        end
    end

endmodule

### hdl/rmsdw_fifo.sv
// short queue between front end and back end
module rmsdw_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rmsdw_pkg::qent_t   push_data,
    input  logic               pop,
    output rmsdw_pkg::qent_t   pop_data,
    output rmsdw_pkg::qstat_t  qstat
);

    rmsdw_pkg::qent_t               ent_reg [rmsdw_pkg::QDEPTH];
    logic [rmsdw_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [rmsdw_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [rmsdw_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [rmsdw_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [rmsdw_pkg::QPTR_W:0]     cnt_reg;
    logic [rmsdw_pkg::QPTR_W:0]     cnt_next;

    localparam logic [rmsdw_pkg::QPTR_W-1:0] LAST_PTR = rmsdw_pkg::QPTR_W'(rmsdw_pkg::QDEPTH - 1);

    assign pop_data    = ent_reg[rd_ptr_reg];
    assign qstat.full  = (cnt_reg == (rmsdw_pkg::QPTR_W + 1)'(rmsdw_pkg::QDEPTH));
    assign qstat.empty = (cnt_reg == '0);

    assign wr_ptr_next = !push ? wr_ptr_reg : (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = !pop ? rd_ptr_reg : (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/rmsdw_back.sv
// back end: mean divide, square root, window rings and result register
module rmsdw_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rmsdw_pkg::qstat_t                   qstat,
    input  rmsdw_pkg::qent_t                    qdata,
    output logic                                pop,
    output logic                                clearing,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [rmsdw_pkg::ERR_W-1:0]  component_error,
    output logic                                vector_done,
    output logic [rmsdw_pkg::RMS_W-1:0]         vector_rms,
    output logic [rmsdw_pkg::OSUM_W-1:0]        newer_window_sum,
    output logic [rmsdw_pkg::OSUM_W-1:0]        older_window_sum,
    output logic [rmsdw_pkg::RMS_W-1:0]         average_error
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_SQRT  = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [rmsdw_pkg::IDX_W-1:0]  LAST_IDX = rmsdw_pkg::IDX_W'(rmsdw_pkg::WINDOW - 1);
    localparam logic [rmsdw_pkg::DCNT_W-1:0] DIV_LAST = rmsdw_pkg::DCNT_W'(rmsdw_pkg::ACC_W - 1);
    localparam logic [rmsdw_pkg::SCNT_W-1:0] SQ_LAST  = rmsdw_pkg::SCNT_W'(rmsdw_pkg::ROOT_W - 1);

    logic [rmsdw_pkg::RMS_W-1:0]        newer_mem [rmsdw_pkg::WINDOW];
    logic [rmsdw_pkg::RMS_W-1:0]        older_mem [rmsdw_pkg::WINDOW];
    logic [rmsdw_pkg::RMS_W-1:0]        newer_rd_reg;
    logic [rmsdw_pkg::RMS_W-1:0]        older_rd_reg;

    logic [2:0]                         state_reg;
    logic [rmsdw_pkg::IDX_W-1:0]        clr_addr_reg;
    logic [rmsdw_pkg::IDX_W-1:0]        pos_reg;
    logic signed [rmsdw_pkg::ERR_W-1:0] err_reg;
    logic [rmsdw_pkg::DVS_W-1:0]        dvs_reg;
    logic [rmsdw_pkg::DVS_W-1:0]        rem_reg;
    logic [rmsdw_pkg::ACC_W-1:0]        quo_reg;
    logic [rmsdw_pkg::DCNT_W-1:0]       dcnt_reg;
    logic [rmsdw_pkg::ACC_W-1:0]        sval_reg;
    logic [rmsdw_pkg::SQR_W-1:0]        srem_reg;
    logic [rmsdw_pkg::ROOT_W-1:0]       root_reg;
    logic [rmsdw_pkg::SCNT_W-1:0]       scnt_reg;
    logic [rmsdw_pkg::SUM_W-1:0]        newer_sum_reg;
    logic [rmsdw_pkg::SUM_W-1:0]        older_sum_reg;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [rmsdw_pkg::ERR_W-1:0] out_err_reg;
    logic                               out_done_reg;
    logic [rmsdw_pkg::RMS_W-1:0]        out_rms_reg;
    logic [rmsdw_pkg::OSUM_W-1:0]       out_nsum_reg;
    logic [rmsdw_pkg::OSUM_W-1:0]       out_osum_reg;
    logic [rmsdw_pkg::RMS_W-1:0]        out_avg_reg;

    logic                               out_free;
    logic                               out_load;
    logic [rmsdw_pkg::DVS_W:0]          d_sh;
    logic                               d_ge;
    logic [rmsdw_pkg::DVS_W:0]          d_diff;
    logic [rmsdw_pkg::DVS_W-1:0]        d_rem;
    logic [rmsdw_pkg::ACC_W-1:0]        d_quo;
    logic [rmsdw_pkg::SQR_W+1:0]        s_sh;
    logic [rmsdw_pkg::SQR_W+1:0]        s_trial;
    logic [rmsdw_pkg::SQR_W+1:0]        s_diff;
    logic                               s_ge;
    logic [rmsdw_pkg::SQR_W-1:0]        s_rem;
    logic [rmsdw_pkg::RMS_W-1:0]        rms_sat;
    logic [rmsdw_pkg::SUM_W-1:0]        avg_full;
    logic [rmsdw_pkg::RMS_W-1:0]        avg_sat;
    logic [rmsdw_pkg::SUM_W-1:0]        newer_sum_next;
    logic [rmsdw_pkg::SUM_W-1:0]        older_sum_next;
    logic                               mem_we;
    logic [rmsdw_pkg::IDX_W-1:0]        mem_addr;
    logic [rmsdw_pkg::RMS_W-1:0]        newer_wdata;
    logic [rmsdw_pkg::RMS_W-1:0]        older_wdata;

    assign out_free = !out_valid_reg || !out_stall;
    assign clearing = (state_reg == ST_CLEAR);
    assign pop      = (state_reg == ST_IDLE) && !qstat.empty && (qdata.last || out_free);

    assign out_load       = (pop && !qdata.last) || ((state_reg == ST_OUT) && out_free);
    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    // restoring divide, one quotient bit a cycle
    assign d_sh   = {rem_reg, quo_reg[rmsdw_pkg::ACC_W-1]};
    assign d_diff = d_sh - {1'b0, dvs_reg};
    assign d_ge   = (d_sh >= {1'b0, dvs_reg});
    assign d_rem  = d_ge ? d_diff[rmsdw_pkg::DVS_W-1:0] : d_sh[rmsdw_pkg::DVS_W-1:0];
    assign d_quo  = {quo_reg[rmsdw_pkg::ACC_W-2:0], d_ge};

    // digit-by-digit root, two radicand bits a cycle
    assign s_sh    = {srem_reg, sval_reg[rmsdw_pkg::ACC_W-1 -: 2]};
    assign s_trial = {2'b00, root_reg, 2'b01};
    assign s_diff  = s_sh - s_trial;
    assign s_ge    = (s_sh >= s_trial);
    assign s_rem   = s_ge ? s_diff[rmsdw_pkg::SQR_W-1:0] : s_sh[rmsdw_pkg::SQR_W-1:0];

    assign rms_sat = (|root_reg[rmsdw_pkg::ROOT_W-1:rmsdw_pkg::RMS_W]) ? '1
                                                   : root_reg[rmsdw_pkg::RMS_W-1:0];

    assign avg_full = rmsdw_pkg::SUM_W'(newer_sum_reg / rmsdw_pkg::WINDOW);
    assign avg_sat  = (|avg_full[rmsdw_pkg::SUM_W-1:rmsdw_pkg::RMS_W]) ? '1
                                                   : avg_full[rmsdw_pkg::RMS_W-1:0];

    assign newer_sum_next = newer_sum_reg - rmsdw_pkg::SUM_W'(newer_rd_reg)
                          + rmsdw_pkg::SUM_W'(rms_sat);
    assign older_sum_next = older_sum_reg - rmsdw_pkg::SUM_W'(older_rd_reg)
                          + rmsdw_pkg::SUM_W'(newer_rd_reg);

    assign mem_we      = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
    assign mem_addr    = clearing ? clr_addr_reg : pos_reg;
    assign newer_wdata = clearing ? '0 : rms_sat;
    assign older_wdata = clearing ? '0 : newer_rd_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            newer_mem[mem_addr] <= newer_wdata;
            older_mem[mem_addr] <= older_wdata;
        end
        newer_rd_reg <= newer_mem[pos_reg];
        older_rd_reg <= older_mem[pos_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            pos_reg       <= '0;
            dcnt_reg      <= '0;
            scnt_reg      <= '0;
            newer_sum_reg <= '0;
            older_sum_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == LAST_IDX)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (pop && qdata.last)
                    begin
                        dcnt_reg  <= DIV_LAST;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == '0)
                    begin
                        scnt_reg  <= SQ_LAST;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    scnt_reg <= scnt_reg - 1'b1;
                    if (scnt_reg == '0)
                    begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    newer_sum_reg <= newer_sum_next;
                    older_sum_reg <= older_sum_next;
                    pos_reg       <= (pos_reg == LAST_IDX) ? '0 : pos_reg + 1'b1;
                    state_reg     <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (pop && qdata.last)
                begin
                    err_reg <= qdata.err;
                    rem_reg <= '0;
                    quo_reg <= qdata.acc;
                    dvs_reg <= rmsdw_pkg::DVS_W'(qdata.cnt);
                end
                else if (pop)
                begin
                    out_err_reg  <= qdata.err;
                    out_done_reg <= 1'b0;
                    out_rms_reg  <= '0;
                    out_nsum_reg <= '0;
                    out_osum_reg <= '0;
                    out_avg_reg  <= '0;
                end
            end
            ST_DIV:
            begin
                rem_reg <= d_rem;
                quo_reg <= d_quo;
                if (dcnt_reg == '0)
                begin
                    sval_reg <= d_quo;
                    srem_reg <= '0;
                    root_reg <= '0;
                end
            end
            ST_SQRT:
            begin
                srem_reg <= s_rem;
                sval_reg <= {sval_reg[rmsdw_pkg::ACC_W-3:0], 2'b00};
                root_reg <= {root_reg[rmsdw_pkg::ROOT_W-2:0], s_ge};
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_err_reg  <= err_reg;
                    out_done_reg <= 1'b1;
                    out_rms_reg  <= rms_sat;
                    out_nsum_reg <= newer_sum_reg[rmsdw_pkg::OSUM_W-1:0];
                    out_osum_reg <= older_sum_reg[rmsdw_pkg::OSUM_W-1:0];
                    out_avg_reg  <= avg_sat;
                end
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    assign out_valid        = out_valid_reg;
    assign component_error  = out_err_reg;
    assign vector_done      = out_done_reg;
    assign vector_rms       = out_rms_reg;
    assign newer_window_sum = out_nsum_reg;
    assign older_window_sum = out_osum_reg;
    assign average_error    = out_avg_reg;

endmodule

### hdl/rmsdw_checker.sv
// port-level checks for the rms error dual window tracker, bound to the top level
module rmsdw_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [rmsdw_pkg::ERR_W-1:0]  component_error,
    input logic                                vector_done,
    input logic [rmsdw_pkg::RMS_W-1:0]         vector_rms,
    input logic [rmsdw_pkg::OSUM_W-1:0]        newer_window_sum,
    input logic [rmsdw_pkg::OSUM_W-1:0]        older_window_sum,
    input logic [rmsdw_pkg::RMS_W-1:0]         average_error
);

    // in reset no word comes out and none goes in
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> (!out_valid && in_stall))
        else $error("word moves during reset");

    // window fields are zero on words that do not end a vector
    a_partial_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !vector_done) |->
            (vector_rms == '0 && newer_window_sum == '0 &&
             older_window_sum == '0 && average_error == '0))
        else $error("window fields set on a partial word");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("out word dropped under stall");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            ($stable(component_error) && $stable(vector_done) &&
             $stable(vector_rms) && $stable(average_error)))
        else $error("out word changed under stall");

endmodule

bind rms_error_dual_window_tracker rmsdw_checker u_rmsdw_checker (.*);

### verif/rmsdw_checker.sv
// checker for the rms error tracker: predicts every result word and compares it field by field
`timescale 1ns / 100ps

module rmsdw_scoreboard
    import rmsdw_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic signed [VAL_W-1:0]    target_value,
    input  logic signed [VAL_W-1:0]    actual_value,
    input  logic                       last_component,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic signed [ERR_W-1:0]    component_error,
    input  logic                       vector_done,
    input  logic [RMS_W-1:0]           vector_rms,
    input  logic [OSUM_W-1:0]          newer_window_sum,
    input  logic [OSUM_W-1:0]          older_window_sum,
    input  logic [RMS_W-1:0]           average_error,
    output int                         fault_count,
    output int                         words_owed
);

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic                    done;
        logic [RMS_W-1:0]        rms;
        logic [OSUM_W-1:0]       nsum;
        logic [OSUM_W-1:0]       osum;
        logic [RMS_W-1:0]        avg;
    } result_word_t;

    localparam logic [ACC_W:0] ACC_SAT = {1'b0, {ACC_W{1'b1}}};

    logic [RMS_W-1:0] newer_hist [WINDOW];
    logic [RMS_W-1:0] older_hist [WINDOW];
    logic [31:0]      newer_total;
    logic [31:0]      older_total;
    logic [IDX_W-1:0] slot;
    logic [ACC_W-1:0] sq_acc;
    logic [CNT_W-1:0] comp_cnt;
    result_word_t     expected_words [$];

    function automatic logic [ROOT_W:0] root_floor(input logic [ACC_W-1:0] v);
        logic [ROOT_W:0] r;
        logic [ROOT_W:0] c;
        r = '0;
        for (int b = ROOT_W; b >= 0; b--)
        begin
            c = r | ((ROOT_W+1)'(1) << b);
            if ((2*ROOT_W+2)'(c) * (2*ROOT_W+2)'(c) <= (2*ROOT_W+2)'(v))
                r = c;
        end
        return r;
    endfunction

    task automatic fold_component(input logic signed [VAL_W-1:0] t,
                                  input logic signed [VAL_W-1:0] a,
                                  input logic fin,
                                  output result_word_t w);
        logic signed [ERR_W-1:0] e;
        logic [ERR_W-1:0]        mag;
        logic [ACC_W:0]          acc_wide;
        logic [ROOT_W:0]         root;
        logic [RMS_W-1:0]        rms;
        logic [31:0]             avg32;
        e = t - a;
        mag = (e < 0) ? -e : e;
        acc_wide = sq_acc + mag * mag;
        sq_acc = (acc_wide > ACC_SAT) ? ACC_SAT[ACC_W-1:0] : acc_wide[ACC_W-1:0];
        if (comp_cnt != '1)
            comp_cnt = comp_cnt + 1'b1;
        w = '0;
        w.err = e;
        if (fin)
        begin
            root = root_floor(sq_acc / comp_cnt);
            rms = (root > (ROOT_W+1)'(16'hffff)) ? '1 : root[RMS_W-1:0];
            older_total = older_total - older_hist[slot] + newer_hist[slot];
            newer_total = newer_total - newer_hist[slot] + rms;
            older_hist[slot] = newer_hist[slot];
            newer_hist[slot] = rms;
            slot = (slot == IDX_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
            avg32 = newer_total / WINDOW;
            w.done = 1'b1;
            w.rms  = rms;
            w.nsum = newer_total[OSUM_W-1:0];
            w.osum = older_total[OSUM_W-1:0];
            w.avg  = (avg32 > 32'hffff) ? '1 : avg32[RMS_W-1:0];
            sq_acc = '0;
            comp_cnt = '0;
        end
    endtask

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        fault_count++;
        if (fault_count <= 200)
            $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        result_word_t w;
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                newer_hist[i] = '0;
                older_hist[i] = '0;
            end
            newer_total = '0;
            older_total = '0;
            slot = '0;
            sq_acc = '0;
            comp_cnt = '0;
            expected_words.delete();
            words_owed = 0;
            fault_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                    flag_mismatch("unexpected result word", component_error, 0);
                else
                begin
                    w = expected_words.pop_front();
                    if (component_error !== w.err)
                        flag_mismatch("component_error", component_error, w.err);
                    if (vector_done !== w.done)
                        flag_mismatch("vector_done", vector_done, w.done);
                    if (vector_rms !== w.rms)
                        flag_mismatch("vector_rms", vector_rms, w.rms);
                    if (newer_window_sum !== w.nsum)
                        flag_mismatch("newer_window_sum", newer_window_sum, w.nsum);
                    if (older_window_sum !== w.osum)
                        flag_mismatch("older_window_sum", older_window_sum, w.osum);
                    if (average_error !== w.avg)
                        flag_mismatch("average_error", average_error, w.avg);
                end
            end
            if (in_valid && !in_stall)
            begin
                fold_component(target_value, actual_value, last_component, w);
                expected_words.push_back(w);
            end
            words_owed = expected_words.size();
        end
    end

endmodule

### verif/tb_top.sv
// testbench top for the rms error tracker: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_top;
    import rmsdw_pkg::*;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [VAL_W-1:0] target_value;
    logic signed [VAL_W-1:0] actual_value;
    logic                    last_component;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [ERR_W-1:0] component_error;
    logic                    vector_done;
    logic [RMS_W-1:0]        vector_rms;
    logic [OSUM_W-1:0]       newer_window_sum;
    logic [OSUM_W-1:0]       older_window_sum;
    logic [RMS_W-1:0]        average_error;
    int                      fault_count;
    int                      words_owed;
    logic                    quiet;
    logic                    hold_go;

    rms_error_dual_window_tracker dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .target_value     (target_value),
        .actual_value     (actual_value),
        .last_component   (last_component),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .component_error  (component_error),
        .vector_done      (vector_done),
        .vector_rms       (vector_rms),
        .newer_window_sum (newer_window_sum),
        .older_window_sum (older_window_sum),
        .average_error    (average_error)
    );

    rmsdw_scoreboard chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .target_value     (target_value),
        .actual_value     (actual_value),
        .last_component   (last_component),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .component_error  (component_error),
        .vector_done      (vector_done),
        .vector_rms       (vector_rms),
        .newer_window_sum (newer_window_sum),
        .older_window_sum (older_window_sum),
        .average_error    (average_error),
        .fault_count      (fault_count),
        .words_owed       (words_owed)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #(10_000_000);
        $display("[rms_error_dual_window_tracker] ERROR");
        $finish;
    end

    function automatic logic signed [VAL_W-1:0] pick_value();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'sh7fff;
            1: v = 16'sh8000;
            2: v = '0;
            3: v = -16'sd1;
            4:
            begin
                v = VAL_W'($urandom_range(0, 64));
                v = v - 16'sd32;
            end
            default: v = VAL_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic signed [VAL_W-1:0] mild_value();
        logic signed [VAL_W-1:0] v;
        v = VAL_W'($urandom_range(0, 1200));
        return v - 16'sd600;
    endfunction

    task automatic send_word(input logic signed [VAL_W-1:0] t,
                             input logic signed [VAL_W-1:0] a,
                             input logic fin);
        while (!quiet && $urandom_range(0, 99) < 30)
        begin
            in_valid       <= 1'b0;
            target_value   <= VAL_W'($urandom);
            actual_value   <= VAL_W'($urandom);
            last_component <= 1'($urandom_range(0, 1));
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        target_value   <= t;
        actual_value   <= a;
        last_component <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_vector(input int len, input bit mild);
        for (int k = 0; k < len; k++)
        begin
            if (mild)
                send_word(mild_value(), mild_value(), k == len - 1);
            else
                send_word(pick_value(), pick_value(), k == len - 1);
        end
    endtask

    // receiver side: random stall, one long hold-off
    initial
    begin : drive_out_stall
        int  hold_left;
        bit  hold_used;
        hold_left = 0;
        hold_used = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_used)
            begin
                hold_left = 300;
                hold_used = 1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !quiet && ($urandom_range(0, 99) < 30);
        end
    end

    initial
    begin : stimulus
        int sent;
        int len;
        int sel;
        int wait_cycles;
        in_valid       = 1'b0;
        target_value   = '0;
        actual_value   = '0;
        last_component = 1'b0;
        quiet          = 1'b0;
        hold_go        = 1'b0;
        rst_n          = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // extremes of the error, zero error, equal nonzero values, then a four-component vector
        send_word(16'sh7fff, 16'sh8000, 1'b1);
        send_word(16'sh8000, 16'sh7fff, 1'b1);
        send_word(16'sh0000, 16'sh0000, 1'b1);
        send_word(16'sh1234, 16'sh1234, 1'b1);
        send_word(16'sh4000, 16'shc000, 1'b0);
        send_word(16'shffff, 16'sh0001, 1'b0);
        send_word(16'sh0000, 16'sh7fff, 1'b0);
        send_word(16'sh8000, 16'sh0000, 1'b1);
        // saturating square accumulator
        for (int k = 0; k < 17; k++)
            send_word(16'sh7fff, 16'sh8000, k == 16);

        sent = 0;
        while (sent < 450)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                len = 1;
            else if (sel <= 6)
                len = 4;
            else if (sel <= 8)
                len = $urandom_range(2, 8);
            else
                len = $urandom_range(9, 24);
            hold_go <= (sent >= 60);
            quiet   <= (sent >= 200 && sent < 300);
            send_vector(len, (sel == 8));
            sent += len;
        end
        quiet <= 1'b0;
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (words_owed != 0 && wait_cycles < 50000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200) @(posedge clk);
        if (fault_count == 0 && words_owed == 0)
            $display("[rms_error_dual_window_tracker] OK");
        else
            $display("[rms_error_dual_window_tracker] ERROR");
        $finish;
    end

endmodule
